@@ sv/vfg_pkg.sv @@
package vfg_pkg;

    localparam int SENSOR_SLOTS = 4;
    localparam int SENSOR_BITS  = 4;

    typedef logic [SENSOR_SLOTS-1:0] t_slots;

    // opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_OPEN   = 3'd1;
    localparam logic [2:0] OP_CLOSE  = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_SERVER = 3'd4;

    // server command bytes
    localparam logic [7:0] SRV_CLOSE = 8'd0;
    localparam logic [7:0] SRV_OPEN  = 8'd1;

    // flood modes
    localparam logic [1:0] MODE_LEVEL_A = 2'd0;
    localparam logic [1:0] MODE_LEVEL_B = 2'd1;
    localparam logic [1:0] MODE_EDGE    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_FLOOD_MODE     = 3'd0;
    localparam logic [2:0] REG_SENSOR_MASK    = 3'd1;
    localparam logic [2:0] REG_OPEN_POLL      = 3'd2;
    localparam logic [2:0] REG_SENSOR_POLL    = 3'd3;
    localparam logic [2:0] REG_MANUAL_HOLDOFF = 3'd4;

    localparam logic [15:0] OPEN_POLL_RST      = 16'd200;
    localparam logic [15:0] SENSOR_POLL_RST    = 16'd1000;
    localparam logic [19:0] MANUAL_HOLDOFF_RST = 20'd30000;

    localparam logic [15:0] MAX16      = 16'hFFFF;
    localparam logic [19:0] MAX20      = 20'hFFFFF;
    localparam logic [6:0]  DRIVE_OPEN = 7'd100;
    localparam logic [6:0]  DRIVE_SHUT = 7'd0;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] server_value;
        logic [7:0] device_level;
        logic [3:0] sensor_levels;
    } t_in_word;

    typedef struct packed {
        logic       drive_valid;
        logic [6:0] drive_level;
        logic [7:0] open_level;
        logic       flood_flag;
        logic       manual_closed_flag;
        logic       rejected;
    } t_out_word;

    typedef struct packed {
        logic   flood;
        t_slots prev_next;
    } t_sensor_result;

endpackage

@@ sv/valve_flood_guard_top.sv @@
// Valve controller with flood sensors. One word is accepted per clock cycle,
// sustained while the output is not stalled by i_out_ready; each word gives
// exactly one result word, through the input register, then the result
// register. Between those two registers every word, tick or command, passes
// once through the update of the controller state. Configuration is written
// through the plain write port; the user must write it only while the block
// is idle, and the block itself does not enforce this. Writes to unused indexes are ignored.
module valve_flood_guard_top
    import vfg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // configuration
    logic [1:0]             r_flood_mode;
    logic [SENSOR_BITS-1:0] r_sensor_mask;
    logic [15:0]            r_open_poll_ms;
    logic [15:0]            r_sensor_poll_ms;
    logic [19:0]            r_manual_holdoff_ms;

    // controller state
    logic [15:0] r_open_elapsed,   n_open_elapsed;
    logic [15:0] r_sensor_elapsed, n_sensor_elapsed;
    logic [19:0] r_cmd_elapsed,    n_cmd_elapsed;
    logic        r_cmd_seen,       n_cmd_seen;
    logic [7:0]  r_last_level,     n_last_level;
    logic        r_flooding,       n_flooding;
    logic        r_manual_closed,  n_manual_closed;
    t_slots      r_prev_sensor,    n_prev_sensor;

    // pipeline
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out, n_out;
    logic      s1_move;

    t_sensor_result sensor_res;

    assign s1_move    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_move;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    vfg_sensor_check u_sensor (
        .i_mode   (r_flood_mode),
        .i_mask   (r_sensor_mask),
        .i_levels (r_in.sensor_levels),
        .i_prev   (r_prev_sensor),
        .o_result (sensor_res)
    );

    always_comb begin
        logic [19:0] ce_inc;
        logic        want_open;
        logic        want_close;
        logic        drive;
        logic [6:0]  level;
        logic        rej;

        n_open_elapsed   = r_open_elapsed;
        n_sensor_elapsed = r_sensor_elapsed;
        n_cmd_elapsed    = r_cmd_elapsed;
        n_cmd_seen       = r_cmd_seen;
        n_last_level     = r_last_level;
        n_flooding       = r_flooding;
        n_manual_closed  = r_manual_closed;
        n_prev_sensor    = r_prev_sensor;

        ce_inc     = (r_cmd_elapsed != MAX20) ? r_cmd_elapsed + 20'd1 : r_cmd_elapsed;
        want_open  = 1'b0;
        want_close = 1'b0;
        drive      = 1'b0;
        level      = DRIVE_SHUT;
        rej        = 1'b0;

        unique case (r_in.opcode)
            OP_TICK: begin
                n_cmd_elapsed = ce_inc;
                if (r_open_elapsed >= r_open_poll_ms) begin
                    n_open_elapsed = '0;
                    if (r_in.device_level != r_last_level &&
                        (!r_cmd_seen || ce_inc > r_manual_holdoff_ms)) begin
                        n_manual_closed = (r_in.device_level == 8'd0);
                    end
                    n_last_level = r_in.device_level;
                end else if (r_open_elapsed != MAX16) begin
                    n_open_elapsed = r_open_elapsed + 16'd1;
                end
                if (r_sensor_elapsed >= r_sensor_poll_ms) begin
                    n_sensor_elapsed = '0;
                    n_prev_sensor    = sensor_res.prev_next;
                    // uses the level sampled on this same tick when the open poll is due, else the last sampled level
                    if ((n_last_level != 8'd0 || !r_flooding) && sensor_res.flood) begin
                        want_close = 1'b1;
                        n_flooding = 1'b1;
                    end
                end else if (r_sensor_elapsed != MAX16) begin
                    n_sensor_elapsed = r_sensor_elapsed + 16'd1;
                end
            end
            OP_OPEN:   want_open = 1'b1;
            OP_CLOSE:  want_close = 1'b1;
            OP_TOGGLE: begin
                if (r_last_level == 8'd0) begin
                    want_open = 1'b1;
                end else begin
                    want_close = 1'b1;
                end
            end
            OP_SERVER: begin
                if (r_in.server_value == SRV_CLOSE) begin
                    want_close = 1'b1;
                end else if (r_in.server_value == SRV_OPEN) begin
                    want_open = 1'b1;
                end else begin
                    rej = 1'b1;
                end
            end
            default: ;
        endcase

        if (want_open) begin
            // open is refused while a flood is present
            n_prev_sensor = sensor_res.prev_next;
            drive         = 1'b1;
            if (sensor_res.flood) begin
                n_flooding = 1'b1;
                level      = DRIVE_SHUT;
            end else begin
                n_flooding = 1'b0;
                level      = DRIVE_OPEN;
            end
        end else if (want_close) begin
            drive = 1'b1;
            level = DRIVE_SHUT;
        end

        if (drive) begin
            n_cmd_seen    = 1'b1;
            n_cmd_elapsed = '0;
        end

        n_out.drive_valid        = drive;
        n_out.drive_level        = level;
        n_out.open_level         = n_last_level;
        n_out.flood_flag         = n_flooding;
        n_out.manual_closed_flag = n_manual_closed;
        n_out.rejected           = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flood_mode        <= MODE_LEVEL_A;
            r_sensor_mask       <= '0;
            r_open_poll_ms      <= OPEN_POLL_RST;
            r_sensor_poll_ms    <= SENSOR_POLL_RST;
            r_manual_holdoff_ms <= MANUAL_HOLDOFF_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FLOOD_MODE:     r_flood_mode        <= i_cfg_data[1:0];
                REG_SENSOR_MASK:    r_sensor_mask       <= i_cfg_data[SENSOR_BITS-1:0];
                REG_OPEN_POLL:      r_open_poll_ms      <= i_cfg_data[15:0];
                REG_SENSOR_POLL:    r_sensor_poll_ms    <= i_cfg_data[15:0];
                REG_MANUAL_HOLDOFF: r_manual_holdoff_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_elapsed   <= '0;
            r_sensor_elapsed <= '0;
            r_cmd_elapsed    <= '0;
            r_cmd_seen       <= 1'b0;
            r_last_level     <= '0;
            r_flooding       <= 1'b0;
            r_manual_closed  <= 1'b0;
            r_prev_sensor    <= '0;
        end else if (s1_move) begin
            r_open_elapsed   <= n_open_elapsed;
            r_sensor_elapsed <= n_sensor_elapsed;
            r_cmd_elapsed    <= n_cmd_elapsed;
            r_cmd_seen       <= n_cmd_seen;
            r_last_level     <= n_last_level;
            r_flooding       <= n_flooding;
            r_manual_closed  <= n_manual_closed;
            r_prev_sensor    <= n_prev_sensor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    a_drive_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && n_out.drive_valid |=> r_cmd_elapsed == '0 && r_cmd_seen)
        else $error("drive did not restart command timer");

    a_reject_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.rejected |-> !o_out_word.drive_valid)
        else $error("rejected word also drives the valve");

    a_open_not_flooded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.drive_valid && o_out_word.drive_level == DRIVE_OPEN
        |-> !o_out_word.flood_flag)
        else $error("valve opened while flood flag set");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

endmodule

@@ sv/vfg_sensor_check.sv @@
module vfg_sensor_check
    import vfg_pkg::*;
(
    input  logic [1:0]             i_mode,
    input  logic [SENSOR_BITS-1:0] i_mask,
    input  logic [SENSOR_BITS-1:0] i_levels,
    input  t_slots                 i_prev,
    output t_sensor_result         o_result
);

    t_slots on_vec;
    t_slots en_vec;

    // slots past the physical sensor bits read as 0
    assign on_vec = t_slots'(i_levels);
    assign en_vec = t_slots'(i_mask);

    always_comb begin
        o_result.flood     = 1'b0;
        o_result.prev_next = i_prev;
        for (int i = 0; i < SENSOR_SLOTS; i++) begin
            if (!en_vec[i]) begin
                o_result.prev_next[i] = 1'b0;
            end else if (i_mode == MODE_LEVEL_A || i_mode == MODE_LEVEL_B) begin
                o_result.prev_next[i] = on_vec[i];
                if (on_vec[i]) begin
                    o_result.flood = 1'b1;
                end
            end else if (i_mode == MODE_EDGE) begin
                if (on_vec[i] && !i_prev[i]) begin
                    o_result.flood = 1'b1;
                end
                o_result.prev_next[i] = on_vec[i];
            end
            // MODE_NONE: enabled slots hold and never flood
        end
    end

endmodule
